[hdl/lfu_pkg.sv]
package lfu_pkg;

  localparam int DEF_SLOTS    = 16;
  localparam int DEF_MAX_FREQ = 255;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_TOUCH  = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_EVICT  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  // scan unit control: clear accumulators, one table entry presented
  typedef struct packed {
    logic clear;
    logic elem_vld;
  } scan_ctl_t;

endpackage

[hdl/lfu_scan.sv]
module lfu_scan #(
  parameter int SLOTS    = lfu_pkg::DEF_SLOTS,
  parameter int MAX_FREQ = lfu_pkg::DEF_MAX_FREQ,
  localparam int IW      = $clog2(SLOTS),
  localparam int CW      = $clog2(MAX_FREQ + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lfu_pkg::scan_ctl_t ctl,
  input  logic [IW-1:0]     elem_idx,
  input  logic              elem_valid,
  input  logic [CW-1:0]     elem_count,
  input  logic [IW-1:0]     elem_rank,
  input  logic [IW-1:0]     tgt_idx,
  input  logic [CW-1:0]     tgt_count,
  input  logic [CW-1:0]     join_count,
  input  logic [CW-1:0]     min_count,
  output logic              pick_found,
  output logic [IW-1:0]     pick_idx,
  output logic              mv_found,
  output logic [IW-1:0]     mv_idx,
  output logic [IW-1:0]     mv_rank,
  output logic [IW-1:0]     join_size,
  output logic              oth_any,
  output logic [CW-1:0]     oth_min
);
  import lfu_pkg::*;

  logic          pick_found_r;
  logic [IW-1:0] pick_idx_r;
  logic          mv_found_r;
  logic [IW-1:0] mv_idx_r;
  logic [IW-1:0] mv_rank_r;
  logic [IW-1:0] join_size_r;
  logic          oth_any_r;
  logic [CW-1:0] oth_min_r;
  logic          hit;
  logic          other;

  assign hit   = ctl.elem_vld && elem_valid;
  assign other = hit && (elem_idx != tgt_idx);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      pick_found_r <= 1'b0;
      mv_found_r   <= 1'b0;
      join_size_r  <= '0;
      oth_any_r    <= 1'b0;
    end else begin
      // head of the lowest bucket
      if (hit && elem_count == min_count && elem_rank == '0) begin
        pick_found_r <= 1'b1;
        pick_idx_r   <= elem_idx;
      end
      // highest rank in the target's bucket is the bucket's tail
      if (other && elem_count == tgt_count && (!mv_found_r || elem_rank > mv_rank_r)) begin
        mv_found_r <= 1'b1;
        mv_idx_r   <= elem_idx;
        mv_rank_r  <= elem_rank;
      end
      if (other && elem_count == join_count) begin
        join_size_r <= join_size_r + 1'b1;
      end
      if (other && (!oth_any_r || elem_count < oth_min_r)) begin
        oth_any_r <= 1'b1;
        oth_min_r <= elem_count;
      end
    end
  end

  assign pick_found = pick_found_r;
  assign pick_idx   = pick_idx_r;
  assign mv_found   = mv_found_r;
  assign mv_idx     = mv_idx_r;
  assign mv_rank    = mv_rank_r;
  assign join_size  = join_size_r;
  assign oth_any    = oth_any_r;
  assign oth_min    = oth_min_r;

endmodule

[hdl/lfu_replacement_policy.sv]
// LFU replacement policy over SLOTS slots.
// Request channel: drive in_req_type / in_slot and pulse start while busy is
// low; the request is taken at that edge.
// Request kinds: insert at frequency 1, touch (frequency + 1, saturating at
// MAX_FREQ), remove, evict (picks head of the lowest-frequency bucket).
// Result channel: out_valid is high for exactly one cycle with status,
// victim slot, slot frequency and current lowest frequency. The receiver
// cannot stall; every request yields exactly one result.
// A slot outside the table is answered from the idle state and busy stays low;
// other requests raise busy the next cycle. A slot in the wrong state is
// answered from the lookup state. Insert, touch and remove run one scan of
// the single-read-port slot table (one entry per cycle, registered read);
// evict runs a pick scan first, and only that when nothing is held. The
// write-back states S_MOVE and S_SET follow the last scan.
// Only one request is in flight, so no forwarding is needed.
// Reset (synchronous, rst_n low): all slots free, lowest frequency 1, no
// result pending. The count/rank table itself is not cleared; per-slot valid
// flops gate every read of it.
module lfu_replacement_policy #(
  parameter int SLOTS    = lfu_pkg::DEF_SLOTS,
  parameter int MAX_FREQ = lfu_pkg::DEF_MAX_FREQ
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_req_type,
  input  logic [3:0] in_slot,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [3:0] out_victim_slot,
  output logic [7:0] out_slot_freq,
  output logic [7:0] out_lowest_freq
);
  import lfu_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(MAX_FREQ + 1);
  localparam int MW = CW + IW;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_PICK, S_PICK_END, S_SCAN, S_MOVE, S_SET
  } state_t;

  state_t        state_r;
  req_t          req_r;
  logic [IW-1:0] slot_r;
  logic [IW-1:0] tgt_idx_r;
  logic [CW-1:0] tgt_cnt_r;
  logic [IW-1:0] tgt_rank_r;
  logic [SLOTS-1:0] valid_r;
  logic [CW-1:0] min_r;

  logic          out_valid_r;
  status_t       out_status_r;
  logic [3:0]    out_victim_r;
  logic [7:0]    out_freq_r;
  logic [7:0]    out_lowest_r;

  // slot table: {count, rank} per slot
  logic [MW-1:0] mem [SLOTS];
  logic [MW-1:0] rdata_r;
  logic [IW-1:0] raddr;
  logic          we;
  logic [IW-1:0] waddr;
  logic [MW-1:0] wdata;
  logic [CW-1:0] rd_cnt;
  logic [IW-1:0] rd_rank;

  // scan sequencer
  logic [IW-1:0] scan_idx_r;
  logic          issue_on_r;
  logic          proc_vld_r;
  logic          proc_last_r;
  logic [IW-1:0] proc_idx_r;
  logic          scan_start;
  scan_ctl_t     scan_ctl;

  logic          pick_found;
  logic [IW-1:0] pick_idx;
  logic          mv_found;
  logic [IW-1:0] mv_idx;
  logic [IW-1:0] mv_rank;
  logic [IW-1:0] join_size;
  logic          oth_any;
  logic [CW-1:0] oth_min;

  logic          in_range;
  logic          tv;
  logic          look_bad;
  logic          sat;
  logic [CW-1:0] nf;
  logic [CW-1:0] join_count;
  logic          t_nv;
  logic [CW-1:0] t_nc;
  logic          t_wr;
  logic          do_move;
  logic [CW-1:0] new_min;

  assign in_range = 32'(in_slot) < SLOTS;
  assign tv       = valid_r[slot_r];
  assign look_bad = (req_r == REQ_INSERT) ? tv : !tv;
  assign sat      = tgt_cnt_r == CW'(MAX_FREQ);
  assign nf       = tgt_cnt_r + CW'(1);
  assign join_count = (req_r == REQ_INSERT) ? CW'(1) : nf;
  assign rd_cnt   = rdata_r[MW-1:IW];
  assign rd_rank  = rdata_r[IW-1:0];

  // new state of the target slot
  always_comb begin
    unique case (req_r)
      REQ_INSERT: begin
        t_nv = 1'b1;
        t_nc = CW'(1);
        t_wr = 1'b1;
      end
      REQ_TOUCH: begin
        t_nv = 1'b1;
        t_nc = sat ? tgt_cnt_r : nf;
        t_wr = !sat;
      end
      REQ_REMOVE, REQ_EVICT: begin
        t_nv = 1'b0;
        t_nc = tgt_cnt_r;
        t_wr = 1'b0;
      end
    endcase
  end

  // target leaves its bucket: the tail member takes over the target's rank
  assign do_move = (req_r == REQ_REMOVE || req_r == REQ_EVICT ||
                    (req_r == REQ_TOUCH && !sat)) &&
                   mv_found && (mv_rank > tgt_rank_r);

  always_comb begin
    if (t_nv) begin
      new_min = (oth_any && oth_min < t_nc) ? oth_min : t_nc;
    end else begin
      new_min = oth_any ? oth_min : CW'(1);
    end
  end

  assign scan_start = (state_r == S_IDLE && start && in_req_type == REQ_EVICT) ||
                      (state_r == S_LOOK && !look_bad) ||
                      (state_r == S_PICK_END && pick_found);

  // table port control
  assign raddr = (state_r == S_IDLE) ? IW'(in_slot) : scan_idx_r;
  assign we    = (state_r == S_MOVE && do_move) || (state_r == S_SET && t_wr);
  assign waddr = (state_r == S_MOVE) ? mv_idx : tgt_idx_r;
  assign wdata = (state_r == S_MOVE) ? {tgt_cnt_r, tgt_rank_r} : {t_nc, join_size};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // scan: issue address, data returns in the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_on_r  <= 1'b0;
      proc_vld_r  <= 1'b0;
      proc_last_r <= 1'b0;
    end else begin
      proc_vld_r  <= issue_on_r;
      proc_last_r <= issue_on_r && (scan_idx_r == IW'(SLOTS - 1));
      proc_idx_r  <= scan_idx_r;
      if (scan_start) begin
        scan_idx_r <= '0;
        issue_on_r <= 1'b1;
      end else if (issue_on_r) begin
        scan_idx_r <= scan_idx_r + 1'b1;
        if (scan_idx_r == IW'(SLOTS - 1)) begin
          issue_on_r <= 1'b0;
        end
      end
    end
  end

  assign scan_ctl.clear    = scan_start;
  assign scan_ctl.elem_vld = proc_vld_r;

  lfu_scan #(
    .SLOTS    (SLOTS),
    .MAX_FREQ (MAX_FREQ)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .elem_idx   (proc_idx_r),
    .elem_valid (valid_r[proc_idx_r]),
    .elem_count (rd_cnt),
    .elem_rank  (rd_rank),
    .tgt_idx    (tgt_idx_r),
    .tgt_count  (tgt_cnt_r),
    .join_count (join_count),
    .min_count  (min_r),
    .pick_found (pick_found),
    .pick_idx   (pick_idx),
    .mv_found   (mv_found),
    .mv_idx     (mv_idx),
    .mv_rank    (mv_rank),
    .join_size  (join_size),
    .oth_any    (oth_any),
    .oth_min    (oth_min)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      min_r       <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r  <= req_t'(in_req_type);
            slot_r <= IW'(in_slot);
            if (in_req_type == REQ_EVICT) begin
              state_r <= S_PICK;
            end else if (!in_range) begin
              // slot outside the table
              out_valid_r  <= 1'b1;
              out_status_r <= ST_BAD;
              out_victim_r <= '0;
              out_freq_r   <= '0;
              out_lowest_r <= 8'(min_r);
            end else begin
              state_r <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          tgt_idx_r  <= slot_r;
          tgt_cnt_r  <= rd_cnt;
          tgt_rank_r <= rd_rank;
          if (look_bad) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_BAD;
            out_victim_r <= '0;
            out_freq_r   <= tv ? 8'(rd_cnt) : 8'd0;
            out_lowest_r <= 8'(min_r);
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_PICK: begin
          if (proc_last_r) begin
            state_r <= S_PICK_END;
          end
        end
        S_PICK_END: begin
          if (pick_found) begin
            tgt_idx_r  <= pick_idx;
            tgt_cnt_r  <= min_r;
            tgt_rank_r <= '0;
            state_r    <= S_SCAN;
          end else begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_EMPTY;
            out_victim_r <= '0;
            out_freq_r   <= '0;
            out_lowest_r <= 8'(min_r);
            state_r      <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (proc_last_r) begin
            state_r <= S_MOVE;
          end
        end
        S_MOVE: begin
          state_r <= S_SET;
        end
        S_SET: begin
          valid_r[tgt_idx_r] <= t_nv;
          min_r        <= new_min;
          out_valid_r  <= 1'b1;
          out_status_r <= ST_OK;
          out_victim_r <= (req_r == REQ_EVICT) ? 4'(tgt_idx_r) : 4'd0;
          out_freq_r   <= t_nv ? 8'(t_nc) : 8'd0;
          out_lowest_r <= 8'(new_min);
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy            = state_r != S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_victim_slot = out_victim_r;
  assign out_slot_freq   = out_freq_r;
  assign out_lowest_freq = out_lowest_r;

endmodule

[hdl/lfu_chk.sv]
module lfu_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [3:0] out_victim_slot,
  input logic [7:0] out_slot_freq,
  input logic [7:0] out_lowest_freq
);
  import lfu_pkg::*;

  // an accepted request either answers at once or holds busy
  a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("request neither answered nor busy");

  // busy only drops when a result goes out
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_fail_victim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_victim_slot == 4'd0)
    else $error("victim reported on failed request");

  // empty store: lowest frequency reads 1, slot frequency 0
  a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_lowest_freq == 8'd1 && out_slot_freq == 8'd0)
    else $error("empty evict with wrong frequencies");

endmodule

bind lfu_replacement_policy lfu_chk u_lfu_chk (.*);

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import lfu_pkg::*;

  localparam int SLOTS        = DEF_SLOTS;
  localparam int MAX_FREQ     = DEF_MAX_FREQ;
  // Longest request is an evict with its two table scans, plus a random gap;
  // the idle limit leaves a wide margin over that.
  localparam int IDLE_LIMIT   = 1000;
  localparam int TAIL_CYCLES  = 2 * SLOTS + 20;
  localparam int RANDOM_ITEMS = 1150;
  localparam int SAT_TOUCHES  = MAX_FREQ + 1;
  localparam int REPORT_LIMIT = 10;

  // One expected result, tagged with the request that caused it.
  typedef struct {
    req_t       req;
    logic [3:0] slot;
    status_t    status;
    logic [3:0] victim;
    logic [7:0] freq;
    logic [7:0] lowest;
  } policy_result_t;

  // Shadow of the replacement policy plus the queue of results still owed.
  class policy_tracker;
    bit             held[SLOTS];
    int unsigned    freq[SLOTS];
    int unsigned    rank[SLOTS];
    int unsigned    lowest;
    policy_result_t pending[$];
    int unsigned    failures;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        held[i] = 1'b0;
        freq[i] = 0;
        rank[i] = 0;
      end
      lowest   = 1;
      failures = 0;
    endfunction

    function int unsigned bucket_size(int unsigned f);
      int unsigned n;
      n = 0;
      for (int i = 0; i < SLOTS; i++)
        if (held[i] && freq[i] == f)
          n++;
      return n;
    endfunction

    // Last member of the bucket takes over the rank of the leaving slot.
    function void leave_bucket(int s);
      int unsigned f;
      int unsigned last;
      f    = freq[s];
      last = bucket_size(f) - 1;
      for (int i = 0; i < SLOTS; i++) begin
        if (i != s && held[i] && freq[i] == f && rank[i] == last) begin
          rank[i] = rank[s];
          break;
        end
      end
    endfunction

    function void refresh_lowest();
      bit          any;
      int unsigned m;
      any = 1'b0;
      m   = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (held[i] && (!any || freq[i] < m)) begin
          m   = freq[i];
          any = 1'b1;
        end
      end
      lowest = any ? m : 1;
    endfunction

    function void release_slot(int s);
      held[s] = 1'b0;
      freq[s] = 0;
      rank[s] = 0;
    endfunction

    function policy_result_t predict_request(req_t req, logic [3:0] slot);
      policy_result_t r;
      int             s;
      int             pick;
      int unsigned    nf;
      s        = int'(slot);
      r.req    = req;
      r.slot   = slot;
      r.status = ST_OK;
      r.victim = '0;
      r.freq   = '0;
      if (req == REQ_EVICT) begin
        pick = SLOTS;
        for (int i = 0; i < SLOTS; i++) begin
          if (held[i] && freq[i] == lowest) begin
            if (pick == SLOTS)
              pick = i;
            if (rank[i] == 0) begin
              pick = i;
              break;
            end
          end
        end
        if (pick == SLOTS) begin
          r.status = ST_EMPTY;
        end else begin
          leave_bucket(pick);
          release_slot(pick);
          r.victim = 4'(pick);
        end
      end else if (s >= SLOTS) begin
        r.status = ST_BAD;
      end else if (req == REQ_INSERT) begin
        if (held[s]) begin
          r.status = ST_BAD;
        end else begin
          rank[s] = bucket_size(1);
          freq[s] = 1;
          held[s] = 1'b1;
        end
      end else if (!held[s]) begin
        r.status = ST_BAD;
      end else if (req == REQ_TOUCH) begin
        if (freq[s] < MAX_FREQ) begin
          nf = freq[s] + 1;
          leave_bucket(s);
          rank[s] = bucket_size(nf);
          freq[s] = nf;
        end
      end else begin
        leave_bucket(s);
        release_slot(s);
      end
      refresh_lowest();
      if (req != REQ_EVICT && s < SLOTS && held[s])
        r.freq = 8'(freq[s]);
      r.lowest = 8'(lowest);
      return r;
    endfunction

    function void note_request(req_t req, logic [3:0] slot);
      pending = {pending, predict_request(req, slot)};
    endfunction

    function void fail(string msg);
      if (failures < REPORT_LIMIT)
        $display("%s", msg);
      failures++;
    endfunction

    function void check_result(logic [1:0] status, logic [3:0] victim,
                               logic [7:0] freq_o, logic [7:0] lowest_o);
      policy_result_t e;
      if (pending.size() == 0) begin
        fail($sformatf("unexpected result: status %0d victim %0d freq %0d lowest %0d",
                       status, victim, freq_o, lowest_o));
        return;
      end
      e = pending.pop_front();
      if (status !== e.status || victim !== e.victim || freq_o !== e.freq ||
          lowest_o !== e.lowest)
        fail($sformatf({"mismatch %s slot %0d (exp/act): status %0d/%0d ",
                        "victim %0d/%0d freq %0d/%0d lowest %0d/%0d"},
                       e.req.name(), e.slot, e.status, status, e.victim, victim,
                       e.freq, freq_o, e.lowest, lowest_o));
    endfunction

    function void flush_leftover();
      if (pending.size() != 0)
        fail($sformatf("%0d results never arrived", pending.size()));
    endfunction

    function int held_count();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++)
        if (held[i])
          n++;
      return n;
    endfunction

    // Caller guarantees at least one slot in the wanted state.
    function logic [3:0] pick_slot(bit want_held);
      int cand[$];
      for (int i = 0; i < SLOTS; i++)
        if (held[i] == want_held)
          cand = {cand, i};
      return 4'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_req_type;
  logic [3:0] in_slot;
  logic       out_valid;
  logic [1:0] out_status;
  logic [3:0] out_victim_slot;
  logic [7:0] out_slot_freq;
  logic [7:0] out_lowest_freq;

  policy_tracker tracker;
  bit            burst;   // when set, the sender never idles between requests

  lfu_replacement_policy #(
    .SLOTS    (SLOTS),
    .MAX_FREQ (MAX_FREQ)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_slot         (in_slot),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_victim_slot (out_victim_slot),
    .out_slot_freq   (out_slot_freq),
    .out_lowest_freq (out_lowest_freq)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sample both channels at the rising edge. The result is checked before
  // the new request is noted, though order would not matter: only one
  // request is ever in flight.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        tracker.check_result(out_status, out_victim_slot, out_slot_freq, out_lowest_freq);
      if (start && !busy)
        tracker.note_request(req_t'(in_req_type), in_slot);
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid)
        idle = 0;
      else
        idle++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  // Drive one request. Entered and left at a falling edge; start stays high
  // on exit so back-to-back requests need no low pulse in between.
  task automatic send_request(req_t req, logic [3:0] slot);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type = req;
    in_slot     = slot;
    start       = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Hold off until every owed result has come back.
  task automatic wait_drained();
    start = 1'b0;
    while (tracker.pending.size() != 0)
      @(negedge clk);
  endtask

  // Mostly legal requests against the current contents, some raw noise.
  task automatic random_request();
    int r;
    int nheld;
    r     = $urandom_range(0, 99);
    nheld = tracker.held_count();
    if (r < 15)
      send_request(req_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    else if (nheld == 0 || (nheld < SLOTS && r < 40))
      send_request(REQ_INSERT, tracker.pick_slot(1'b0));
    else if (r < 75)
      send_request(REQ_TOUCH, tracker.pick_slot(1'b1));
    else if (r < 88)
      send_request(REQ_REMOVE, tracker.pick_slot(1'b1));
    else
      send_request(REQ_EVICT, 4'($urandom_range(0, 15)));
  endtask

  initial begin
    tracker     = new();
    burst       = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req_type = REQ_INSERT;
    in_slot     = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty evict, misuse of free and held slots, bucket reorder
    // on removal, victim taken from the head of the lowest bucket.
    send_request(REQ_EVICT, 4'd0);     // nothing held
    send_request(REQ_TOUCH, 4'd3);     // free slot
    send_request(REQ_REMOVE, 4'd12);   // free slot
    send_request(REQ_INSERT, 4'd0);
    send_request(REQ_INSERT, 4'd15);
    send_request(REQ_INSERT, 4'd0);    // already held
    send_request(REQ_TOUCH, 4'd0);
    send_request(REQ_TOUCH, 4'd0);
    send_request(REQ_TOUCH, 4'd15);
    send_request(REQ_INSERT, 4'd5);
    send_request(REQ_INSERT, 4'd10);
    send_request(REQ_INSERT, 4'd9);
    send_request(REQ_REMOVE, 4'd5);    // tail of bucket 1 fills the gap
    send_request(REQ_EVICT, 4'd15);    // slot field ignored
    send_request(REQ_TOUCH, 4'd10);
    send_request(REQ_EVICT, 4'd0);
    send_request(REQ_REMOVE, 4'd15);
    send_request(REQ_EVICT, 4'd7);
    send_request(REQ_EVICT, 4'd0);
    send_request(REQ_EVICT, 4'd0);     // empty again
    send_request(REQ_INSERT, 4'd6);
    send_request(REQ_TOUCH, 4'd9);     // free slot
    send_request(REQ_REMOVE, 4'd6);

    // Let the pipe go fully quiet once before continuing.
    wait_drained();

    // Saturation: drive one slot past MAX_FREQ, then leave it alone so the
    // lowest frequency reaches the top too.
    send_request(REQ_INSERT, 4'd7);
    send_request(REQ_INSERT, 4'd2);
    for (int i = 0; i < SAT_TOUCHES; i++)
      send_request(REQ_TOUCH, 4'd7);
    send_request(REQ_TOUCH, 4'd2);
    send_request(REQ_REMOVE, 4'd2);
    send_request(REQ_TOUCH, 4'd7);     // touch at max with nothing else held
    send_request(REQ_EVICT, 4'd0);

    // Random traffic; idle-free bursts now and then.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0)
        burst = ($urandom_range(0, 3) == 0);
      random_request();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    tracker.flush_leftover();
    if (tracker.failures == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
